>>> rtl/core/ltrk_pkg.sv
// shared constants for the lis length tracker
// no dependencies; imported by lis_length_tracker
`timescale 1ns / 1ps
`default_nettype none

package ltrk_pkg;

  // width of one sequence value
  localparam int unsigned ValueW = 32;

  // default number of tail table entries
  localparam int unsigned DefMaxLen = 1024;

  // flipping the sign bit lets an unsigned compare order signed values
  localparam logic [ValueW-1:0] SignBias = {1'b1, {(ValueW-1){1'b0}}};

endpackage

`default_nettype wire

>>> rtl/core/lis_length_tracker.sv
// top level of the lis length tracker: sequencer, binary search and tail table
// depends on ltrk_pkg and ltrk_ram
`timescale 1ns / 1ps
`default_nettype none

// Tracks the length of the longest strictly increasing subsequence of a stream
// of signed 32-bit words, by the patience method: a ram holds, for every length,
// the smallest value that can end an increasing run of that length, kept sorted.
// Each input word is looked up by binary search over the first lis_length
// entries (first entry greater or equal to the value); the value replaces that
// entry, or is appended when none is found. One result word comes out per input
// word, carrying the new length and a sticky overflow flag. Setting tuser (the
// first flag) clears the length and the overflow flag before the word is handled,
// so a new sequence starts; old table contents are never read again. When the
// table holds MaxLen entries and an append is needed, the word is dropped, the
// length stays at MaxLen and overflow is set until the next first flag.
// Steps: on acceptance the first probe is read from the ram; the search then
// makes one halving step per read of the single ram read port; a write-back
// step then updates the table and loads the result. A word that arrives with
// an empty table skips the search.
// The block takes no new word until the previous one has written back. A
// finished result sits in an output register, so the next word may be accepted
// while it waits; write-back then holds until that register is free. No
// clearing pass is needed after reset.
module lis_length_tracker #(
  parameter int unsigned MaxLen = ltrk_pkg::DefMaxLen,
  localparam int unsigned LenW = $clog2(MaxLen + 1),
  localparam int unsigned OutW = ((LenW + 1 + 7) / 8) * 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // input words
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  wire logic [ltrk_pkg::ValueW-1:0] s_axis_tdata_i,  // value (signed)
  input  wire logic                        s_axis_tuser_i,  // first
  // result words
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  output logic [OutW-1:0]                  m_axis_tdata_o   // lis_length, overflow, zero pad
);

  import ltrk_pkg::*;

  localparam int unsigned AddrW = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam logic [LenW-1:0] MaxLenV = LenW'(MaxLen);
  localparam logic [LenW-1:0] OneV = LenW'(1);

  // sequencer states
  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StSearch = 2'd1;
  localparam logic [1:0] StWrite  = 2'd2;

  logic [1:0]        state_d, state_q;
  logic [ValueW-1:0] key_d, key_q;
  logic [LenW-1:0]   len_d, len_q;
  logic              ovf_d, ovf_q;
  logic [LenW-1:0]   lo_d, lo_q;
  logic [LenW-1:0]   hi_d, hi_q;
  logic [LenW-1:0]   mid_d, mid_q;
  logic              out_valid_d, out_valid_q;
  logic [LenW-1:0]   out_len_d, out_len_q;
  logic              out_ovf_d, out_ovf_q;

  logic              in_take;
  logic              out_free;
  logic [LenW-1:0]   start_len;
  logic              tail_lt;
  logic [LenW-1:0]   nlo, nhi;
  logic [LenW-1:0]   nmid;

  // ram side
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic              ram_re;
  logic [AddrW-1:0]  ram_raddr;
  logic [ValueW-1:0] ram_rdata;

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign start_len       = s_axis_tuser_i ? '0 : len_q;

  // one halving step of the search: compare the tail just read with the key
  assign tail_lt = (ram_rdata < key_q);
  assign nlo     = tail_lt ? (mid_q + OneV) : lo_q;
  assign nhi     = tail_lt ? hi_q : mid_q;
  assign nmid    = nlo + ((nhi - nlo) >> 1);

  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    len_d       = len_q;
    ovf_d       = ovf_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    out_valid_d = out_valid_q;
    out_len_d   = out_len_q;
    out_ovf_d   = out_ovf_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_take) begin
          key_d = s_axis_tdata_i ^ SignBias;
          len_d = start_len;
          if (s_axis_tuser_i) begin
            ovf_d = 1'b0;
          end
          lo_d  = '0;
          hi_d  = start_len;
          mid_d = start_len >> 1;
          if (start_len != '0) begin
            // first probe at the middle of the live entries
            ram_re    = 1'b1;
            ram_raddr = mid_d[AddrW-1:0];
            state_d   = StSearch;
          end else begin
            state_d = StWrite;
          end
        end
      end

      StSearch: begin
        lo_d  = nlo;
        hi_d  = nhi;
        mid_d = nmid;
        if (nlo < nhi) begin
          ram_re    = 1'b1;
          ram_raddr = nmid[AddrW-1:0];
        end else begin
          state_d = StWrite;
        end
      end

      StWrite: begin
        // lo_q holds the position of the first tail not below the key
        if (out_free) begin
          if (lo_q < len_q) begin
            ram_we    = 1'b1;
            ram_waddr = lo_q[AddrW-1:0];
            out_len_d = len_q;
            out_ovf_d = ovf_q;
          end else if (len_q < MaxLenV) begin
            ram_we    = 1'b1;
            ram_waddr = len_q[AddrW-1:0];
            len_d     = len_q + OneV;
            out_len_d = len_q + OneV;
            out_ovf_d = ovf_q;
          end else begin
            // table full: drop the value and flag it
            ovf_d     = 1'b1;
            out_len_d = len_q;
            out_ovf_d = 1'b1;
          end
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    out_len_q <= out_len_d;
    out_ovf_q <= out_ovf_d;
  end

  // tail table, stored with the sign bit flipped
  ltrk_ram #(
    .Width (ValueW),
    .Depth (MaxLen)
  ) u_tail_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (key_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutW - LenW - 1){1'b0}}, out_ovf_q, out_len_q};

endmodule

`default_nettype wire

>>> rtl/core/ltrk_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies; used for the tail table of lis_length_tracker
`timescale 1ns / 1ps
`default_nettype none

module ltrk_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// self-checking testbench for lis_length_tracker: directed, overflow, backpressure and random tests
// depends on ltrk_pkg and the lis_length_tracker rtl, nothing else
`timescale 1ns / 1ps

module tb_top;
  import ltrk_pkg::*;

  localparam int unsigned MaxLen = DefMaxLen;
  localparam int unsigned LenW   = $clog2(MaxLen + 1);
  localparam int unsigned OutW   = ((LenW + 1 + 7) / 8) * 8;

  localparam logic signed [ValueW-1:0] ValMin = {1'b1, {(ValueW-1){1'b0}}};
  localparam logic signed [ValueW-1:0] ValMax = {1'b0, {(ValueW-1){1'b1}}};

  // result word fields, length in the low bits, overflow just above
  typedef struct packed {
    logic            ovf;
    logic [LenW-1:0] len;
  } lis_result_t;

  typedef logic signed [ValueW-1:0] value_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [ValueW-1:0] s_axis_tdata_i = '0;  // value (signed)
  logic              s_axis_tuser_i = 1'b0;  // first
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [OutW-1:0]   m_axis_tdata_o;  // lis_length, overflow, zero pad

  lis_length_tracker #(
    .MaxLen(MaxLen)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: patience table of smallest tails, one per run length
  // ---------------------------------------------------------------------------
  value_t      tail_mem [MaxLen];
  int unsigned run_len = 0;
  bit          run_ovf = 1'b0;

  lis_result_t lengths_due [$];  // expected result words, oldest first

  int err_count       = 0;
  int words_sent      = 0;
  int results_seen    = 0;
  int overflow_words  = 0;
  int sequences_begun = 0;

  function automatic lis_result_t track_value(value_t v, bit first);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lis_result_t res;
    if (first) begin
      run_len = 0;
      run_ovf = 1'b0;
    end
    // first tail not less than v, searched over live entries only
    lo = 0;
    hi = run_len;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tail_mem[mid] < v) lo = mid + 1;
      else hi = mid;
    end
    if (lo < run_len) begin
      tail_mem[lo] = v;
    end else if (run_len < MaxLen) begin
      tail_mem[run_len] = v;
      run_len++;
    end else begin
      run_ovf = 1'b1;  // table full, value dropped
    end
    res.len = run_len[LenW-1:0];
    res.ovf = run_ovf;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  int burst_left  = 0;
  bit steady_send = 1'b0;  // no gaps while set

  task automatic send_word(input value_t v, input bit first);
    @(negedge clk_i);
    if (!steady_send && burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 250)
                                                : $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= v;
    s_axis_tuser_i  <= first;
    do @(posedge clk_i); while (!s_axis_tready_o);
    lengths_due.insert(lengths_due.size(), track_value(v, first));
    words_sent++;
    if (first) sequences_begun++;
  endtask

  // drop tvalid and wait for every outstanding result
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (lengths_due.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: own stall pattern, plus long hold-offs on request
  // ---------------------------------------------------------------------------
  int hold_reqs  = 0;
  int holds_done = 0;
  int rx_mode    = 0;
  int rx_left    = 0;
  int rx_tick    = 0;

  always begin
    @(negedge clk_i);
    rx_tick++;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_reqs != holds_done) begin
      // long hold-off, lets the block fill and push back on its input
      m_axis_tready_i <= 1'b0;
      repeat (300) @(negedge clk_i);
      holds_done++;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
        0: m_axis_tready_i <= 1'b1;
        1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready_i <= rx_tick[2];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // checker: every accepted result word against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    lis_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      if (m_axis_tdata_o[LenW]) overflow_words++;
      if (lengths_due.size() == 0) begin
        $error("result word with no expectation waiting: data 0x%0h", m_axis_tdata_o);
        err_count++;
      end else begin
        want = lengths_due.pop_front();
        if (m_axis_tdata_o[LenW-1:0] !== want.len) begin
          $error("lis_length mismatch: expected %0d, actual %0d",
                 want.len, m_axis_tdata_o[LenW-1:0]);
          err_count++;
        end
        if (m_axis_tdata_o[LenW] !== want.ovf) begin
          $error("overflow mismatch: expected %0d, actual %0d",
                 want.ovf, m_axis_tdata_o[LenW]);
          err_count++;
        end
        if (m_axis_tdata_o[OutW-1:LenW+1] !== '0) begin
          $error("pad mismatch: expected 0, actual 0x%0h", m_axis_tdata_o[OutW-1:LenW+1]);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // extremes, equal values, replacement, descent and restarts
  task automatic test_directed_edges();
    send_word(0, 1'b0);        // straight after reset, no first flag
    send_word(ValMin, 1'b0);   // replaces the only tail
    send_word(ValMax, 1'b0);   // append
    send_word(ValMax, 1'b0);   // equal value, no growth
    send_word(-1, 1'b0);
    send_word(0, 1'b0);
    send_word(1, 1'b0);
    send_word(ValMax, 1'b1);   // new sequence starting at the top
    send_word(ValMin, 1'b0);
    send_word(ValMin, 1'b0);
    send_word(5, 1'b0);
    send_word(4, 1'b0);
    send_word(3, 1'b0);
    send_word(-5, 1'b1);
    send_word(-4, 1'b0);
    send_word(-3, 1'b0);
    send_word(-2, 1'b0);
    send_word(-3, 1'b0);       // equal to an inner tail
    send_word(100, 1'b0);
    send_word(0, 1'b1);
    send_word(0, 1'b1);        // back-to-back restarts
    send_word(ValMin, 1'b1);
    send_word(ValMax, 1'b0);
    wait_drained();
  endtask

  // fill the whole table, then push past it
  task automatic test_table_overflow();
    longint v;
    for (int i = 0; i < MaxLen + 6; i++) begin
      v = longint'(ValMin) + longint'(i) * 64'sd4000000;
      send_word(value_t'(v), i == 0);
    end
    send_word(0, 1'b0);        // replacement keeps the length, flag stays
    send_word(ValMax, 1'b0);   // another dropped append
    send_word(ValMax, 1'b0);   // still above every tail, dropped again
    send_word(5, 1'b1);        // restart clears the flag
    send_word(6, 1'b0);
    wait_drained();
  endtask

  // receiver holds off while words keep coming
  task automatic test_backpressure();
    value_t v;
    steady_send = 1'b1;
    hold_reqs++;
    v = $urandom;
    for (int i = 0; i < 30; i++) begin
      send_word(v, i == 0);
      v = v + int'($urandom_range(0, 50)) - 10;
    end
    steady_send = 1'b0;
    wait_drained();
  endtask

  // mostly well-formed sequences of varied shape, some stray restarts
  task automatic test_random_sequences();
    int     stop_at;
    int     seq_len;
    int     shape;
    bit     first;
    value_t v;
    value_t prev;
    stop_at = words_sent + 900;
    while (words_sent < stop_at) begin
      seq_len = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 400)
                                              : $urandom_range(1, 40);
      shape   = $urandom_range(0, 4);
      prev    = $urandom;
      if ($urandom_range(0, 40) == 0) hold_reqs++;
      for (int i = 0; i < seq_len; i++) begin
        case (shape)
          0: v = $urandom;
          1: v = prev + int'($urandom_range(0, 1000)) - 200;  // rising with dips
          2: v = int'($urandom_range(0, 15)) - 8;             // many repeats
          3: begin
            case ($urandom_range(0, 4))
              0: v = ValMin;
              1: v = ValMax;
              2: v = 0;
              3: v = -1;
              default: v = 1;
            endcase
          end
          default: v = prev - int'($urandom_range(0, 1000)); // falling
        endcase
        prev  = v;
        first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
        send_word(v, first);
      end
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_edges();
    test_table_overflow();
    test_backpressure();
    test_random_sequences();

    repeat (32) @(posedge clk_i);
    $display("run covered %0d words in %0d sequences, %0d results checked",
             words_sent, sequences_begun, results_seen);
    $display("%0d result words carried the overflow flag", overflow_words);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
